@@ design/rna_pkg.sv @@
// ----------------------------------------------------------------------------
// rna_pkg
// Types and constants shared by the rational number ALU modules.
// ----------------------------------------------------------------------------
package rna_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int DEN_BITS     = OPERAND_BITS - 1;
   localparam int MAG_BITS     = 2 * OPERAND_BITS;
   localparam int NUM_OUT_BITS = 32;
   localparam int DEN_OUT_BITS = 31;

   localparam logic [3:0] CMD_ADD = 4'd0;
   localparam logic [3:0] CMD_SUB = 4'd1;
   localparam logic [3:0] CMD_MUL = 4'd2;
   localparam logic [3:0] CMD_DIV = 4'd3;
   localparam logic [3:0] CMD_GT  = 4'd4;
   localparam logic [3:0] CMD_LT  = 4'd5;
   localparam logic [3:0] CMD_GE  = 4'd6;
   localparam logic [3:0] CMD_LE  = 4'd7;
   localparam logic [3:0] CMD_EQ  = 4'd8;
   localparam logic [3:0] CMD_NE  = 4'd9;

   typedef struct packed {
      logic [3:0]                     cmd;
      logic signed [OPERAND_BITS-1:0] a_num;
      logic [DEN_BITS-1:0]            a_den;
      logic signed [OPERAND_BITS-1:0] b_num;
      logic [DEN_BITS-1:0]            b_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_OUT_BITS-1:0] res_num;
      logic [DEN_OUT_BITS-1:0]        res_den;
      logic                           truth;
      logic                           div_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      logic                neg;
      logic [MAG_BITS-1:0] den;
      logic                trivial;
      logic                truth;
      logic                div_by_zero;
   } work_type;

endpackage

@@ design/rna_front.sv @@
// ----------------------------------------------------------------------------
// rna_front
// Accepts items, forms cross products and classifies the command.
// ----------------------------------------------------------------------------
module rna_front import rna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_item,
   output logic     work_push,
   input  logic     work_full,
   output work_type work_item
);

   localparam int PW = MAG_BITS;

   logic                 valid_ff, valid_in;
   logic signed [PW-1:0] lhs_ff, rhs_ff, nn_ff;
   logic [PW-1:0]        dd_ff, dv_ff;
   logic [3:0]           cmd_ff;
   logic                 bneg_ff, bzero_ff;

   logic [DEN_BITS-1:0]     ad, bd;
   logic [OPERAND_BITS-1:0] bmag;
   logic                    accept;

   assign req_full  = valid_ff & work_full;
   assign accept    = req_push & ~req_full;
   assign work_push = valid_ff & ~work_full;

   assign ad   = (req_item.a_den == '0) ? DEN_BITS'(1) : req_item.a_den;
   assign bd   = (req_item.b_den == '0) ? DEN_BITS'(1) : req_item.b_den;
   assign bmag = req_item.b_num[OPERAND_BITS-1] ? OPERAND_BITS'(-req_item.b_num)
                                                : OPERAND_BITS'(req_item.b_num);

   always_comb begin
      valid_in = valid_ff;
      if (work_push) valid_in = 1'b0;
      if (accept)    valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lhs_ff   <= req_item.a_num * $signed({1'b0, bd});
         rhs_ff   <= req_item.b_num * $signed({1'b0, ad});
         nn_ff    <= req_item.a_num * req_item.b_num;
         dd_ff    <= PW'(ad) * PW'(bd);
         dv_ff    <= PW'(ad) * PW'(bmag);
         cmd_ff   <= req_item.cmd;
         bneg_ff  <= req_item.b_num[OPERAND_BITS-1];
         bzero_ff <= (req_item.b_num == '0);
      end
   end

   logic signed [PW:0] lhs_x, rhs_x, num;
   logic [PW-1:0]      den;
   logic               neg, reduce, truth, dz;

   assign lhs_x = {lhs_ff[PW-1], lhs_ff};
   assign rhs_x = {rhs_ff[PW-1], rhs_ff};

   always_comb begin
      num    = '0;
      den    = PW'(1);
      neg    = 1'b0;
      reduce = 1'b0;
      truth  = 1'b0;
      dz     = 1'b0;
      unique case (cmd_ff)
         CMD_ADD: begin num = lhs_x + rhs_x; den = dd_ff; reduce = 1'b1; end
         CMD_SUB: begin num = lhs_x - rhs_x; den = dd_ff; reduce = 1'b1; end
         CMD_MUL: begin num = {nn_ff[PW-1], nn_ff}; den = dd_ff; reduce = 1'b1; end
         CMD_DIV: begin
            if (bzero_ff) dz = 1'b1;
            else begin num = lhs_x; den = dv_ff; reduce = 1'b1; end
         end
         CMD_GT:  truth = lhs_ff >  rhs_ff;
         CMD_LT:  truth = lhs_ff <  rhs_ff;
         CMD_GE:  truth = lhs_ff >= rhs_ff;
         CMD_LE:  truth = lhs_ff <= rhs_ff;
         CMD_EQ:  truth = lhs_ff == rhs_ff;
         CMD_NE:  truth = lhs_ff != rhs_ff;
         default: ;
      endcase
      neg = num[PW] ^ ((cmd_ff == CMD_DIV) & bneg_ff);
   end

   always_comb begin
      work_item.mag         = num[PW] ? PW'(-num) : PW'(num);
      work_item.neg         = neg;
      work_item.den         = den;
      work_item.trivial     = ~reduce | (num == '0);
      work_item.truth       = truth;
      work_item.div_by_zero = dz;
   end

endmodule

@@ design/rna_queue.sv @@
// ----------------------------------------------------------------------------
// rna_queue
// Two-entry queue between the front and the reduction unit.
// ----------------------------------------------------------------------------
module rna_queue import rna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  work_type push_item,
   input  logic     pop,
   output logic     empty,
   output work_type pop_item
);

   work_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff ^ do_push;
      rd_in    = rd_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

@@ design/rna_reduce.sv @@
// ----------------------------------------------------------------------------
// rna_reduce
// Binary gcd, two restoring dividers and the result register.
// ----------------------------------------------------------------------------
module rna_reduce import rna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   output logic     work_pop,
   input  work_type work_item,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_item
);

   localparam int MW = MAG_BITS;
   localparam int KW = $clog2(MW);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_GCD  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [MW-1:0] u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [MW-1:0] qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic          neg_ff, neg_in, truth_ff, truth_in, dz_ff, dz_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [MW:0]   tn, td;
   logic signed [MW:0] snum;

   assign work_pop  = (state_ff == S_IDLE) & work_valid;
   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign tn   = {rn_ff, qn_ff[MW-1]};
   assign td   = {rd_ff, qd_ff[MW-1]};
   assign snum = neg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      neg_in       = neg_ff;
      truth_in     = truth_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               truth_in = work_item.truth;
               dz_in    = work_item.div_by_zero;
               if (work_item.trivial) begin
                  qn_in    = '0;
                  qd_in    = MW'(1);
                  neg_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  u_in     = work_item.mag;
                  v_in     = work_item.den;
                  qn_in    = work_item.mag;
                  qd_in    = work_item.den;
                  neg_in   = work_item.neg;
                  k_in     = '0;
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            priority if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff == v_ff) begin
               g_in     = u_ff << k_ff;
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else if (u_ff > v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         S_DIV: begin
            qn_in = {qn_ff[MW-2:0], 1'b0};
            qd_in = {qd_ff[MW-2:0], 1'b0};
            if (tn >= {1'b0, g_ff}) begin
               rn_in    = MW'(tn - {1'b0, g_ff});
               qn_in[0] = 1'b1;
            end else begin
               rn_in = MW'(tn);
            end
            if (td >= {1'b0, g_ff}) begin
               rd_in    = MW'(td - {1'b0, g_ff});
               qd_in[0] = 1'b1;
            end else begin
               rd_in = MW'(td);
            end
            cnt_in = cnt_ff + KW'(1);
            if (cnt_ff == KW'(MW - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in.res_num     = NUM_OUT_BITS'(snum);
               rsp_in.res_den     = DEN_OUT_BITS'(qd_ff);
               rsp_in.truth       = truth_ff;
               rsp_in.div_by_zero = dz_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      v_ff     <= v_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      qn_ff    <= qn_in;
      qd_ff    <= qd_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      neg_ff   <= neg_in;
      truth_ff <= truth_in;
      dz_ff    <= dz_in;
      rsp_ff   <= rsp_in;
   end

endmodule

@@ design/rational_number_alu.sv @@
// ----------------------------------------------------------------------------
// rational_number_alu
// Compare, zero and error items skip the reduction; reduced results take
// one binary gcd halve or subtract a cycle, then 32 restoring divide steps
// in the shared back end. The back end works on one item at a time, and the
// two-entry queue holds later items meanwhile; a result that waits to be
// taken holds the back end.
// Reset: synchronous, clears the queue and drops all items in flight.
// ----------------------------------------------------------------------------
module rational_number_alu import rna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_item,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_item
);

   logic     f_push, f_full, q_empty, q_pop;
   work_type f_item, q_item;

   rna_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .work_push (f_push),
      .work_full (f_full),
      .work_item (f_item)
   );

   rna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .full      (f_full),
      .push_item (f_item),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_item)
   );

   rna_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .work_valid (~q_empty),
      .work_pop   (q_pop),
      .work_item  (q_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

@@ design/rna_checker.sv @@
// ----------------------------------------------------------------------------
// rna_checker
// Port-level checks on the rational number ALU.
// ----------------------------------------------------------------------------
module rna_checker import rna_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_item
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("waiting item changed");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_item.res_den != '0))
      else $error("zero denominator");

   a_flag_fraction: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.truth || rsp_item.div_by_zero)) |->
      (rsp_item.res_num == '0 && rsp_item.res_den == DEN_OUT_BITS'(1)))
      else $error("flagged item without 0/1 fraction");

endmodule

bind rational_number_alu rna_checker u_rna_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);
